### design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i / rst_ni pair.
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### design/upd_pkg.sv
`default_nettype none

package upd_pkg;

  // Characters with a special meaning in the encoded string
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharSpace   = 8'h20;

  // Default depth of the command queue between front and back
  localparam int CmdFifoDepth = 2;

  // Up to three decoded bytes settled by one input byte, oldest in slot 0.
  // last marks the final byte of the group as the end of the string.
  typedef struct packed {
    logic [1:0]      num;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    hex_val = v[3:0];
  endfunction

endpackage

`default_nettype wire

### design/upd_front.sv
`default_nettype none

`include "assert_macros.svh"

module upd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          last_i,
  output upd_pkg::cmd_t      cmd_o
);
  import upd_pkg::*;

  localparam logic [1:0] PhaseIdle  = 2'd0;
  localparam logic [1:0] PhasePct   = 2'd1;
  localparam logic [1:0] PhaseDigit = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;

  logic [1:0] pfx_num;
  logic       do_plain;
  logic       plain_emit;
  logic [7:0] plain_byte;
  logic [1:0] plain_phase;
  cmd_t       cmd;

  // Escape handling: bytes held from earlier, then the current byte if plain
  always_comb begin
    held_d   = held_q;
    pfx_num  = 2'd0;
    do_plain = 1'b1;
    cmd      = '0;
    phase_d  = phase_q;

    unique case (phase_q)
      PhasePct: begin
        if (is_hex(byte_i) && !last_i) begin
          held_d   = byte_i;
          do_plain = 1'b0;
          phase_d  = PhaseDigit;
        end else begin
          cmd.bytes[0] = CharPercent;
          pfx_num      = 2'd1;
        end
      end
      PhaseDigit: begin
        if (is_hex(byte_i)) begin
          cmd.bytes[0] = {hex_val(held_q), hex_val(byte_i)};
          pfx_num      = 2'd1;
          do_plain     = 1'b0;
          phase_d      = PhaseIdle;
        end else begin
          cmd.bytes[0] = CharPercent;
          cmd.bytes[1] = held_q;
          pfx_num      = 2'd2;
        end
      end
      default: begin
        pfx_num = 2'd0;
      end
    endcase

    // Ordinary decode of the current byte
    plain_emit  = 1'b1;
    plain_byte  = byte_i;
    plain_phase = PhaseIdle;
    if (byte_i == CharPercent) begin
      if (!last_i) begin
        plain_emit  = 1'b0;
        plain_phase = PhasePct;
      end
    end else if (byte_i == CharPlus) begin
      plain_byte = CharSpace;
    end

    if (do_plain) begin
      phase_d = plain_phase;
      if (plain_emit) begin
        unique case (pfx_num)
          2'd0:    cmd.bytes[0] = plain_byte;
          2'd1:    cmd.bytes[1] = plain_byte;
          default: cmd.bytes[2] = plain_byte;
        endcase
      end
    end

    cmd.num  = pfx_num + {1'b0, do_plain & plain_emit};
    cmd.last = last_i;
  end

  assign cmd_o = cmd;

  // Escape state moves only on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
      held_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  `ASSERT_DEF(a_held_is_hex, (phase_q == PhaseDigit) |-> is_hex(held_q), "held digit not hex")

endmodule

`default_nettype wire

### design/upd_cmd_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module upd_cmd_fifo #(
  parameter int DEPTH = upd_pkg::CmdFifoDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire upd_pkg::cmd_t wr_data_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output upd_pkg::cmd_t      rd_data_o,
  output logic               empty_o
);
  import upd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_DEF(a_no_overflow, wr_i |-> !full_o, "command queue overflow")
  `ASSERT_DEF(a_no_underflow, rd_i |-> !empty_o, "command queue underflow")
  `ASSERT_DEF(a_count_bound, count_q <= CntW'(DEPTH), "command queue count out of range")

endmodule

`default_nettype wire

### design/upd_back.sv
`default_nettype none

`include "assert_macros.svh"

module upd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire upd_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [7:0]         byte_o,
  output logic               last_o
);
  import upd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       advance;
  logic       emit;
  logic       final_slot;
  logic [7:0] sel_byte;

  // Output register frees up when empty or being taken this cycle
  assign advance    = !out_valid_q || pop_i;
  assign emit       = cmd_valid_i && advance;
  assign final_slot = (idx_q == (cmd_i.num - 2'd1));
  assign cmd_pop_o  = emit && final_slot;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = cmd_i.bytes[0];
      2'd1:    sel_byte = cmd_i.bytes[1];
      default: sel_byte = cmd_i.bytes[2];
    endcase
  end

  // Walk through the slots of the head command, one byte per transfer
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      idx_d       = final_slot ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= sel_byte;
      out_last_q <= cmd_i.last && final_slot;
    end
  end

  assign empty_o = !out_valid_q;
  assign byte_o  = out_byte_q;
  assign last_o  = out_last_q;

  `ASSERT_DEF(a_idx_in_cmd, cmd_valid_i |-> (idx_q < cmd_i.num), "slot index past command")
  `ASSERT_DEF(a_idx_idle_zero, !cmd_valid_i |-> (idx_q == 2'd0), "slot index left mid-command")

endmodule

`default_nettype wire

### design/url_percent_decoder.sv
`default_nettype none

// URL percent decoder. Takes one encoded byte per transfer (in_last_i on the
// final byte of a string) and returns the decoded bytes, out_last_o on the
// final one: '+' becomes a space, '%' with two hex digits becomes the byte
// they encode, and a broken or cut-short escape passes through as it was.
// One byte is accepted per cycle while full is low; one result is delivered
// per cycle while pop is held and empty is low. An input byte settles zero
// to three results, and the output port drains them one per cycle, so a byte
// that closes a broken escape keeps the output busy for up to three results.
// The command queue (CMD_FIFO_DEPTH entries, the command being drained among
// them) takes CMD_FIFO_DEPTH - 1 further commands meanwhile; with the
// default depth full then holds input until the long command has drained.
// Results pass through the command queue and then the output register.
module url_percent_decoder #(
  parameter int CMD_FIFO_DEPTH = upd_pkg::CmdFifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import upd_pkg::*;

  logic accept;
  logic fifo_wr;
  logic fifo_rd;
  logic fifo_empty;
  cmd_t front_cmd;
  cmd_t head_cmd;

  assign accept  = push && !full;
  // Bytes that only open or extend an escape leave nothing to deliver
  assign fifo_wr = accept && (front_cmd.num != 2'd0);

  upd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .last_i   (in_last_i),
    .cmd_o    (front_cmd)
  );

  upd_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fifo_wr),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (fifo_rd),
    .rd_data_o (head_cmd),
    .empty_o   (fifo_empty)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!fifo_empty),
    .cmd_pop_o   (fifo_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .byte_o      (out_byte_o),
    .last_o      (out_last_o)
  );

endmodule

`default_nettype wire
